### hw/rtl/wav_stream_sample_decoder_defines.svh
// Assertion helper macros for the WAV stream sample decoder.
`ifndef WAV_STREAM_SAMPLE_DECODER_DEFINES_SVH
`define WAV_STREAM_SAMPLE_DECODER_DEFINES_SVH
// Assert that a condition implies a consequence at the same edge.
`define WSD_ASSERT_IMP(label, clk, rstn, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error(msg);
// Assert that a condition implies a consequence at the next edge.
`define WSD_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, tags and status codes of the WAV stream sample decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package wsd_pkg;
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [15:0] FmtPcm   = 16'h0001;
  localparam logic [15:0] FmtFloat = 16'h0003;
  localparam logic [15:0] FmtExt   = 16'hFFFE;
  localparam logic [7:0]  CharLo   = 8'h20;
  localparam logic [7:0]  CharHi   = 8'h7E;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadRiff   = 3'd1;
  localparam logic [2:0] StBadWave   = 3'd2;
  localparam logic [2:0] StBadFmt    = 3'd3;
  localparam logic [2:0] StIncomp    = 3'd4;
  localparam logic [2:0] StUnsupp    = 3'd5;
  localparam logic [2:0] StPcm24Len  = 3'd6;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [31:0] sample_word;
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
  } result_t;

  // Results caused by one byte: up to a sample and a status.
  typedef struct packed {
    logic    smp_vld;
    result_t smp;
    logic    sts_vld;
    result_t sts;
  } step_t;
endpackage
`default_nettype wire

### hw/rtl/wsd_sample_conv.sv
// ----------------------------------------------------------------------------
// wsd_sample_conv
// Convert a gathered PCM16/PCM24/float32 sample into an IEEE single word.
// ----------------------------------------------------------------------------
`default_nettype none
module wsd_sample_conv (
  input  wire logic [31:0] gather_i,
  input  wire logic [1:0]  width_sel_i,   // 1: PCM16, 2: PCM24, else float
  output logic      [31:0] word_o
);
  logic [23:0] mag;
  logic        sgn;
  logic [4:0]  lz;
  logic [23:0] norm;
  logic [7:0]  expo;
  logic [7:0]  bias;

  // Magnitude of the signed value; v/2^k is exact in single precision.
  always_comb begin
    if (width_sel_i == 2'd1) begin
      sgn  = gather_i[15];
      mag  = sgn ? {8'd0, 16'(~gather_i[15:0] + 16'd1)} : {8'd0, gather_i[15:0]};
      bias = 8'd127 - 8'd15;
    end else begin
      sgn  = gather_i[23];
      mag  = sgn ? 24'(~gather_i[23:0] + 24'd1) : gather_i[23:0];
      bias = 8'd127 - 8'd23;
    end
  end

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (mag[i]) lz = 5'(23 - i);
    end
  end

  assign norm = mag << lz;
  assign expo = bias + 8'd23 - {3'd0, lz};

  always_comb begin
    if (width_sel_i != 2'd1 && width_sel_i != 2'd2) begin
      word_o = gather_i;
    end else if (mag == 24'd0) begin
      word_o = 32'd0;
    end else begin
      word_o = {sgn, expo, norm[22:0]};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Byte-wise RIFF/WAVE walker; results for one byte per cycle while take_i is high.
// ----------------------------------------------------------------------------
`default_nettype none
module wsd_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           take_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           fin_i,
  output wsd_pkg::step_t      step_o
);
  typedef enum logic [3:0] {
    PhRiff, PhRsize, PhWave, PhId, PhLen, PhFmt, PhData, PhSkip, PhPad, PhDone
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d, tag_q, tag_d, len_q, len_d, left_q, left_d;
  logic [15:0] ftag_q, ftag_d, chan_q, chan_d, bits_q, bits_d;
  logic [31:0] rate_q, rate_d, gat_q, gat_d;
  logic [1:0]  gcnt_q, gcnt_d;
  logic        fseen_q, fseen_d, dseen_q, dseen_d, err_q, err_d;

  logic [1:0]  k;
  logic [31:0] gat_new, word;
  logic [1:0]  wsel;
  logic        fail;
  logic [2:0]  fcode;
  logic        smp_fire;
  logic [2:0]  end_st;

  assign wsel = (bits_q == 16'd16) ? 2'd1 : (bits_q == 16'd24) ? 2'd2 : 2'd3;

  wsd_sample_conv u_conv (.gather_i(gat_new), .width_sel_i(wsel), .word_o(word));

  function automatic logic plaus(input logic [31:0] t);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (t[8*i +: 8] < wsd_pkg::CharLo || t[8*i +: 8] > wsd_pkg::CharHi) ok = 1'b0;
    end
    return ok;
  endfunction

  // Multiple of three: 4 is 1 mod 3, so fold the 2-bit digits with a small adder tree.
  function automatic logic is_mul3(input logic [31:0] v);
    logic [3:0] bs [4];
    logic [5:0] s;
    logic [3:0] t;
    logic [2:0] u;
    for (int j = 0; j < 4; j++) begin
      bs[j] = ({2'd0, v[8*j +: 2]} + {2'd0, v[8*j+2 +: 2]}) +
              ({2'd0, v[8*j+4 +: 2]} + {2'd0, v[8*j+6 +: 2]});
    end
    s = ({2'd0, bs[0]} + {2'd0, bs[1]}) + ({2'd0, bs[2]} + {2'd0, bs[3]});
    t = {2'd0, s[1:0]} + {2'd0, s[3:2]} + {2'd0, s[5:4]};
    u = {1'b0, t[1:0]} + {1'b0, t[3:2]};
    return (u == 3'd0) || (u == 3'd3);
  endfunction

  always_comb begin
    logic [31:0] lenw;
    logic [4:0]  fi;
    logic        endc;
    logic [31:0] sh;
    lenw = '0; fi = '0; endc = 1'b0; sh = '0;
    phase_d = phase_q; cnt_d = cnt_q; tag_d = tag_q; len_d = len_q; left_d = left_q;
    ftag_d = ftag_q; chan_d = chan_q; rate_d = rate_q; bits_d = bits_q;
    fseen_d = fseen_q; dseen_d = dseen_q; err_d = err_q;
    gat_d = gat_q; gcnt_d = gcnt_q;
    fail = 1'b0; fcode = wsd_pkg::StOk; smp_fire = 1'b0;
    k = cnt_q[1:0];
    sh = {24'd0, byte_i} << {k, 3'b000};
    gat_new = gat_q | ({24'd0, byte_i} << {gcnt_q, 3'b000});
    if (!err_q) begin
      case (phase_q)
        PhRiff, PhWave, PhId: begin
          tag_d = tag_q | sh;
          cnt_d = {30'd0, k} + 32'd1;
          if (k == 2'd3) begin
            cnt_d = '0;
            if (phase_q == PhRiff) begin
              if (tag_d != wsd_pkg::TagRiff) begin
                fail = 1'b1; fcode = wsd_pkg::StBadRiff;
              end else phase_d = PhRsize;
              tag_d = '0;
            end else if (phase_q == PhWave) begin
              if (tag_d != wsd_pkg::TagWave) begin
                fail = 1'b1; fcode = wsd_pkg::StBadWave;
              end else phase_d = PhId;
              tag_d = '0;
            end else if (fseen_q && dseen_q && !plaus(tag_d)) begin
              phase_d = PhDone;
            end else begin
              phase_d = PhLen;
              len_d = '0;
            end
          end
        end
        PhRsize: begin
          cnt_d = {30'd0, k} + 32'd1;
          if (k == 2'd3) begin
            cnt_d = '0; tag_d = '0; phase_d = PhWave;
          end
        end
        PhLen: begin
          lenw = len_q | sh;
          len_d = lenw;
          cnt_d = {30'd0, k} + 32'd1;
          if (k == 2'd3) begin
            left_d = lenw; cnt_d = '0;
            if (tag_q == wsd_pkg::TagFmt && !fseen_q) begin
              if (lenw < 32'd16) begin
                fail = 1'b1; fcode = wsd_pkg::StBadFmt;
              end else begin
                ftag_d = '0; chan_d = '0; rate_d = '0; bits_d = '0; phase_d = PhFmt;
              end
            end else if (tag_q == wsd_pkg::TagData && !dseen_q && lenw != 32'd0) begin
              if (!fseen_q) begin
                fail = 1'b1; fcode = wsd_pkg::StUnsupp;
              end else if (chan_q == 16'd0 || rate_q == 32'd0 || bits_q == 16'd0) begin
                fail = 1'b1; fcode = wsd_pkg::StIncomp;
              end else if (ftag_q == wsd_pkg::FmtPcm && bits_q == 16'd24) begin
                if (!is_mul3(lenw)) begin
                  fail = 1'b1; fcode = wsd_pkg::StPcm24Len;
                end
              end else if (!((ftag_q == wsd_pkg::FmtPcm && bits_q == 16'd16) ||
                             (ftag_q == wsd_pkg::FmtFloat && bits_q == 16'd32))) begin
                fail = 1'b1; fcode = wsd_pkg::StUnsupp;
              end
              if (!fail) begin
                gat_d = '0; gcnt_d = '0; phase_d = PhData;
              end
            end else if (lenw == 32'd0) begin
              endc = 1'b1;
            end else begin
              phase_d = PhSkip;
            end
          end
        end
        PhFmt: begin
          fi = cnt_q[4:0];
          if (fi < 5'd2) ftag_d = ftag_q | 16'({8'd0, byte_i} << {fi[0], 3'b000});
          else if (fi < 5'd4) chan_d = chan_q | 16'({8'd0, byte_i} << {fi[0], 3'b000});
          else if (fi < 5'd8) rate_d = rate_q | sh;
          else if (fi == 5'd14) bits_d = bits_q | {8'd0, byte_i};
          else if (fi == 5'd15) bits_d = bits_q | {byte_i, 8'd0};
          else if (fi == 5'd24) ftag_d = {8'd0, byte_i};
          else if (fi == 5'd25) ftag_d = ftag_q | {byte_i, 8'd0};
          cnt_d = cnt_q + 32'd1;
          left_d = left_q - 32'd1;
          if (fi == 5'd15) begin
            if (ftag_d != wsd_pkg::FmtExt) begin
              fseen_d = 1'b1;
              if (left_d == 32'd0) endc = 1'b1; else phase_d = PhSkip;
            end else if (len_q < 32'd40) begin
              ftag_d = (bits_d == 16'd16 || bits_d == 16'd24) ? wsd_pkg::FmtPcm
                                                                 : wsd_pkg::FmtExt;
              fseen_d = 1'b1;
              if (left_d == 32'd0) endc = 1'b1; else phase_d = PhSkip;
            end
          end else if (fi >= 5'd25) begin
            fseen_d = 1'b1;
            if (left_d == 32'd0) endc = 1'b1; else phase_d = PhSkip;
          end
        end
        PhData: begin
          gat_d = gat_new;
          if ({1'b0, gcnt_q} + 3'd1 >= bits_q[5:3]) begin
            smp_fire = 1'b1; gat_d = '0; gcnt_d = '0;
          end else gcnt_d = gcnt_q + 2'd1;
          left_d = left_q - 32'd1;
          if (left_d == 32'd0) begin
            gat_d = '0; gcnt_d = '0; dseen_d = 1'b1; endc = 1'b1;
          end
        end
        PhSkip: begin
          left_d = left_q - 32'd1;
          if (left_d == 32'd0) endc = 1'b1;
        end
        PhPad: begin
          phase_d = PhId; cnt_d = '0; tag_d = '0;
        end
        default: ;
      endcase
      if (endc) begin
        phase_d = len_q[0] ? PhPad : PhId;
        cnt_d = '0; tag_d = '0;
      end
      if (fail) err_d = 1'b1;
    end
  end

  // End-of-file status from the phase reached after this byte's work.
  always_comb begin
    case (phase_d)
      PhRiff:          end_st = wsd_pkg::StBadRiff;
      PhRsize, PhWave: end_st = wsd_pkg::StBadWave;
      PhFmt:           end_st = wsd_pkg::StBadFmt;
      default:         end_st = dseen_d ? wsd_pkg::StOk : wsd_pkg::StIncomp;
    endcase
  end

  always_comb begin
    step_o = '0;
    step_o.smp_vld = smp_fire;
    step_o.smp.sample_word = word;
    step_o.sts_vld = fail || (fin_i && !err_q);
    step_o.sts.kind = 1'b1;
    step_o.sts.status = fail ? fcode : end_st;
    step_o.sts.channel_count = chan_d;
    step_o.sts.rate_hz = rate_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhRiff; cnt_q <= '0; tag_q <= '0; len_q <= '0; left_q <= '0;
      ftag_q <= '0; chan_q <= '0; rate_q <= '0; bits_q <= '0;
      fseen_q <= 1'b0; dseen_q <= 1'b0; err_q <= 1'b0; gat_q <= '0; gcnt_q <= '0;
    end else if (take_i) begin
      if (fin_i) begin
        phase_q <= PhRiff; cnt_q <= '0; tag_q <= '0; len_q <= '0; left_q <= '0;
        ftag_q <= '0; chan_q <= '0; rate_q <= '0; bits_q <= '0;
        fseen_q <= 1'b0; dseen_q <= 1'b0; err_q <= 1'b0; gat_q <= '0; gcnt_q <= '0;
      end else begin
        phase_q <= phase_d; cnt_q <= cnt_d; tag_q <= tag_d; len_q <= len_d;
        left_q <= left_d; ftag_q <= ftag_d; chan_q <= chan_d; rate_q <= rate_d;
        bits_q <= bits_d; fseen_q <= fseen_d; dseen_q <= dseen_d; err_q <= err_d;
        gat_q <= gat_d; gcnt_q <= gcnt_d;
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/wsd_out_queue.sv
// ----------------------------------------------------------------------------
// wsd_out_queue
// Small result FIFO: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none
module wsd_out_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire wsd_pkg::step_t   step_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output wsd_pkg::result_t      res_o,
  output logic                  last_o
);
  localparam int Depth = 4;
  wsd_pkg::result_t  mem_q [Depth];
  logic              lst_q [Depth];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [1:0] n_in;
  logic       do_pop;

  assign n_in    = push_i ? 2'({1'b0, step_i.smp_vld} + {1'b0, step_i.sts_vld}) : 2'd0;
  assign room_o  = cnt_q <= 3'd2 || (cnt_q == 3'd3 && pop_i);
  assign valid_o = cnt_q != 3'd0;
  assign do_pop  = valid_o && pop_i;
  assign res_o   = mem_q[rp_q];
  assign last_o  = lst_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && step_i.smp_vld) begin
      mem_q[wp_q] <= step_i.smp;
      lst_q[wp_q] <= !step_i.sts_vld;
    end
    if (push_i && step_i.sts_vld) begin
      mem_q[step_i.smp_vld ? wp_q + 2'd1 : wp_q] <= step_i.sts;
      lst_q[step_i.smp_vld ? wp_q + 2'd1 : wp_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + n_in;
      rp_q  <= rp_q + {1'b0, do_pop};
      cnt_q <= cnt_q + {1'b0, n_in} - {2'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/wav_stream_sample_decoder.sv
// ----------------------------------------------------------------------------
// wav_stream_sample_decoder
// Streaming RIFF/WAVE parser that turns file bytes into float samples.
// ----------------------------------------------------------------------------
// Feed the file one byte per item; the block takes one byte per clock while
// its four-entry result queue has room for two more results, so it runs at
// one byte per cycle unless the output side stalls. Each byte yields zero,
// one or two results (a sample and/or a status); run_end_o marks the last
// result of a byte. final_byte_i ends the file, sends the end status (unless
// an error was already reported) and rearms the parser.
`default_nettype none
`include "wav_stream_sample_decoder_defines.svh"
module wav_stream_sample_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  file_byte_i,
  input  wire logic        final_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [31:0]      sample_word_o,
  output logic [2:0]       status_o,
  output logic [15:0]      channel_count_o,
  output logic [31:0]      rate_hz_o,
  output logic             run_end_o
);
  wsd_pkg::step_t   step;
  wsd_pkg::result_t res;
  logic room, take;

  // Accept while the queue can hold two more results.
  assign in_stall_o = !room;
  assign take = in_valid_i && room;

  wsd_parser u_parser (
    .clk_i, .rst_ni, .take_i(take), .byte_i(file_byte_i), .fin_i(final_byte_i),
    .step_o(step)
  );

  wsd_out_queue u_queue (
    .clk_i, .rst_ni, .push_i(take), .step_i(step), .room_o(room),
    .valid_o(out_valid_o), .pop_i(!out_stall_i), .res_o(res), .last_o(run_end_o)
  );

  assign kind_o          = res.kind;
  assign sample_word_o   = res.sample_word;
  assign status_o        = res.status;
  assign channel_count_o = res.channel_count;
  assign rate_hz_o       = res.rate_hz;

  `WSD_ASSERT_IMP(a_stall_no_take, clk_i, rst_ni, in_stall_o, !take, "took item while stalled")
  `WSD_ASSERT_NEXT(a_fin_out, clk_i, rst_ni, take && final_byte_i && step.sts_vld, out_valid_o, "no status after final byte")
  `WSD_ASSERT_IMP(a_sts_last, clk_i, rst_ni, out_valid_o && kind_o, run_end_o, "status not last")
endmodule
`default_nettype wire
